>>> rtl/rsl_pkg.sv
// Shared types, register indexes and constants for the ramped motion setpoint limiter.
package rsl_pkg;

  localparam int TICKS_PER_SECOND = 50;
  localparam int QUEUE_DEPTH      = 4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 31;

  localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_MODE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RAMP_GAIN        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_VELOCITY     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ACCELERATION = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_NEAR_TOLERANCE   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SNAP_TOLERANCE   = 3'd5;

  localparam logic [1:0] MODE_PASS     = 2'd0;
  localparam logic [1:0] MODE_SPEED    = 2'd1;
  localparam logic [1:0] MODE_POSITION = 2'd2;

  localparam logic ACTION_TARGET = 1'b0;
  localparam logic ACTION_LOAD   = 1'b1;

  localparam logic [16:0] ONE_Q16           = 17'd65536;
  localparam logic [16:0] NEAR_FRACTION_Q16 = 17'd26214;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_PASS,
    OP_SPEED,
    OP_POSITION
  } op_t;

  typedef enum logic [2:0] {
    BAND_PASS     = 3'd0,
    BAND_SPEED    = 3'd1,
    BAND_SNAP     = 3'd2,
    BAND_NEAR     = 3'd3,
    BAND_PROFILED = 3'd4
  } band_t;

  typedef struct packed {
    logic               action;
    logic signed [31:0] value;
  } setpoint_t;

  typedef struct packed {
    logic signed [31:0] command;
    band_t              band;
  } drive_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
  } entry_t;

  typedef struct packed {
    logic [1:0]  control_mode;
    logic [16:0] ramp_gain;
    logic [30:0] max_velocity;
    logic [30:0] max_acceleration;
    logic [30:0] near_tolerance;
    logic [30:0] snap_tolerance;
  } cfg_t;

endpackage

>>> rtl/rsl_div.sv
// Unsigned division by a constant through a multi-cycle reciprocal multiply, 16 bits per cycle.
module rsl_div #(
  parameter int NUM_W = 44,
  parameter int DEN   = 100
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  localparam int DEN_W = $clog2(DEN + 1);
  localparam int SH    = NUM_W + DEN_W;
  localparam int RW    = NUM_W + 2;
  localparam int CH    = 16;
  localparam int STEPS = (RW + CH - 1) / CH;
  localparam int RP    = STEPS * CH;
  localparam int PRW   = NUM_W + RP;
  localparam int CW    = $clog2(STEPS + 1);

  localparam logic [SH:0]   POW     = {1'b1, {SH{1'b0}}};
  localparam logic [SH:0]   RECIP   = POW / (SH + 1)'(DEN) + (SH + 1)'(1);
  localparam logic [RP-1:0] RECIP_P = RP'(RECIP);

  logic [CW-1:0]       cnt;
  logic [NUM_W-1:0]    work;
  logic [RP-1:0]       recip;
  logic [PRW-1:0]      acc;
  logic [NUM_W+CH-1:0] part;
  logic [PRW-1:0]      acc_next;

  always_comb begin
    part     = work * recip[RP-1 -: CH];
    acc_next = (acc << CH) + PRW'(part);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      work  <= num;
      recip <= RECIP_P;
      acc   <= '0;
      cnt   <= CW'(STEPS);
      busy  <= 1'b1;
    end else if (busy) begin
      recip <= recip << CH;
      acc   <= acc_next;
      cnt   <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quo = NUM_W'(acc >> SH);

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");

endmodule

>>> rtl/rsl_fifo.sv
// Short request queue between the classifying front end and the execution sequencer.
module rsl_fifo #(
  parameter int DEPTH = rsl_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rsl_pkg::entry_t push_data,
  input  logic           pop,
  output logic           valid,
  output rsl_pkg::entry_t head,
  output logic           full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rsl_pkg::entry_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign valid = (count != '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        mem[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> count != '0)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

>>> rtl/rsl_front.sv
// Request front end: accept setpoint requests and classify them into queue operations.
module rsl_front (
  input  logic               setpoint_valid,
  input  rsl_pkg::setpoint_t setpoint,
  input  logic [1:0]         control_mode,
  input  logic               full,
  output logic               setpoint_stall,
  output logic               push,
  output rsl_pkg::entry_t    push_data
);

  assign setpoint_stall = full;
  assign push           = setpoint_valid && !full;

  always_comb begin
    push_data.value = setpoint.value;
    if (setpoint.action == rsl_pkg::ACTION_LOAD) begin
      push_data.op = rsl_pkg::OP_LOAD;
    end else begin
      case (control_mode)
        rsl_pkg::MODE_SPEED:    push_data.op = rsl_pkg::OP_SPEED;
        rsl_pkg::MODE_POSITION: push_data.op = rsl_pkg::OP_POSITION;
        default:                push_data.op = rsl_pkg::OP_PASS;
      endcase
    end
  end

endmodule

>>> rtl/rsl_back.sv
// Execution sequencer: kept position and velocity, ramp and profile arithmetic, output register.
module rsl_back #(
  parameter int TICKS_PER_SECOND = rsl_pkg::TICKS_PER_SECOND
) (
  input  logic            clk,
  input  logic            rst,
  input  rsl_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  rsl_pkg::entry_t q_head,
  output logic            q_pop,
  output logic            drive_valid,
  input  logic            drive_stall,
  output rsl_pkg::drive_t drive
);

  localparam int TW        = $clog2(TICKS_PER_SECOND + 1);
  localparam int PW        = TW + 34;
  localparam int FW        = $clog2(4 * TICKS_PER_SECOND + 1) + 1;
  localparam int VW        = FW + 32;
  localparam int NW0       = TW + 35;
  localparam int DIV_STEPS = (NW0 + 3) / 4;
  localparam int NW        = 4 * DIV_STEPS;
  localparam int NS        = NW + 1;
  localparam int SW        = NW + 2;

  localparam logic signed [TW:0]   T_S    = (TW + 1)'(TICKS_PER_SECOND);
  localparam logic signed [FW-1:0] F_S    = FW'(4 * TICKS_PER_SECOND);
  localparam logic signed [NS-1:0] T_N    = NS'(TICKS_PER_SECOND);
  localparam logic signed [NS-1:0] TT2_N  = NS'(2 * TICKS_PER_SECOND * TICKS_PER_SECOND);
  localparam logic signed [NS-1:0] D1M1_N = NS'(2 * TICKS_PER_SECOND - 1);
  localparam logic signed [NS-1:0] D2M1_N =
    NS'(4 * TICKS_PER_SECOND * TICKS_PER_SECOND - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_MUL,
    S_FIN,
    S_ACCD,
    S_ACCM,
    S_ACC,
    S_NUM,
    S_SIGN,
    S_DIV,
    S_PFIN
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    logic signed [31:0] r;
    if ((&v[SW-1:31]) || !(|v[SW-1:31])) begin
      r = v[31:0];
    end else if (v[SW-1]) begin
      r = {1'b1, 31'b0};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_mag(input logic signed [PW-1:0] v,
                                                   input logic [30:0] lim);
    logic signed [PW-1:0] l;
    logic signed [PW-1:0] nl;
    logic signed [31:0]   r;
    l  = $signed({{(PW - 31){1'b0}}, lim});
    nl = -l;
    if (v > l) begin
      r = l[31:0];
    end else if (v < nl) begin
      r = nl[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  state_t               state;
  rsl_pkg::op_t         op;
  rsl_pkg::band_t       band;
  logic signed [31:0]   tgt;
  logic signed [32:0]   gap;
  logic signed [32:0]   diff;
  logic signed [50:0]   prod;
  logic signed [PW-1:0] vraw;
  logic signed [31:0]   vel;
  logic signed [32:0]   accd;
  logic signed [PW-1:0] aprod;
  logic signed [VW-1:0] pv4t;
  logic signed [31:0]   acc;
  logic signed [NS-1:0] n1;
  logic signed [NS-1:0] n2;
  logic                 neg1;
  logic                 neg2;
  logic signed [31:0]   last_position;
  logic signed [31:0]   last_velocity;

  logic                 out_free;
  logic                 out_load;
  logic [32:0]          mag;
  logic signed [32:0]   mul_a;
  logic signed [17:0]   mul_b;
  logic signed [50:0]   prod_next;
  logic signed [PW-1:0] vraw_next;
  rsl_pkg::band_t       band_next;
  logic signed [50:0]   rnd;
  logic signed [34:0]   step;
  logic signed [31:0]   fin_base;
  logic signed [31:0]   fin_cmd;
  logic signed [NS-1:0] mt1;
  logic signed [NS-1:0] mt2;
  logic [NW-1:0]        m1;
  logic [NW-1:0]        m2;
  logic                 div_start;
  logic                 busy1;
  logic                 busy2;
  logic [NW-1:0]        q1;
  logic [NW-1:0]        q2;
  logic signed [NS-1:0] qs1;
  logic signed [NS-1:0] qs2;
  logic signed [31:0]   new_vel;
  logic signed [31:0]   pf_cmd;

  assign out_free = !drive_valid || !drive_stall;
  assign q_pop    = (state == S_IDLE) && q_valid &&
                    ((q_head.op != rsl_pkg::OP_PASS) || out_free);
  assign out_load = (q_pop && (q_head.op == rsl_pkg::OP_PASS)) ||
                    ((state == S_FIN) && (band != rsl_pkg::BAND_PROFILED) && out_free) ||
                    ((state == S_PFIN) && out_free);

  always_comb begin
    mag   = gap[32] ? -gap : gap;
    mul_a = (op == rsl_pkg::OP_SPEED) ? diff : gap;
    mul_b = $signed({1'b0, (op == rsl_pkg::OP_SPEED) ? cfg.ramp_gain
                                                       : rsl_pkg::NEAR_FRACTION_Q16});
    prod_next = mul_a * mul_b;
    vraw_next = gap * T_S;
    if (op == rsl_pkg::OP_SPEED) begin
      band_next = rsl_pkg::BAND_SPEED;
    end else if (mag <= 33'(cfg.snap_tolerance)) begin
      band_next = rsl_pkg::BAND_SNAP;
    end else if (mag <= 33'(cfg.near_tolerance)) begin
      band_next = rsl_pkg::BAND_NEAR;
    end else begin
      band_next = rsl_pkg::BAND_PROFILED;
    end
    rnd      = prod + 51'sd32768;
    step     = rnd[50:16];
    fin_base = (op == rsl_pkg::OP_SPEED) ? last_velocity : last_position;
    fin_cmd  = (band == rsl_pkg::BAND_SNAP) ? tgt : sat32(SW'(fin_base) + SW'(step));
    mt1 = n1[NS-1] ? (D1M1_N - n1) : n1;
    mt2 = n2[NS-1] ? (D2M1_N - n2) : n2;
    m1  = mt1[NW-1:0];
    m2  = mt2[NW-1:0];
    qs1 = neg1 ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
    qs2 = neg2 ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
    new_vel = sat32(SW'(last_velocity) + SW'(qs1));
    pf_cmd  = sat32(SW'(last_position) + SW'(qs2));
  end

  assign div_start = (state == S_SIGN);

  rsl_div #(.NUM_W(NW), .DEN(2 * TICKS_PER_SECOND)) u_div_vel (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (m1),
    .busy  (busy1),
    .quo   (q1)
  );

  rsl_div #(.NUM_W(NW), .DEN(4 * TICKS_PER_SECOND * TICKS_PER_SECOND)) u_div_pos (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (m2),
    .busy  (busy2),
    .quo   (q2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      drive_valid   <= 1'b0;
      last_position <= '0;
      last_velocity <= '0;
    end else begin
      if (out_load) begin
        drive_valid <= 1'b1;
      end else if (drive_valid && !drive_stall) begin
        drive_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            tgt <= q_head.value;
            op  <= q_head.op;
            case (q_head.op)
              rsl_pkg::OP_LOAD: begin
                last_position <= q_head.value;
              end
              rsl_pkg::OP_PASS: begin
                drive.command <= q_head.value;
                drive.band    <= rsl_pkg::BAND_PASS;
              end
              default: begin
                state <= S_DIFF;
              end
            endcase
          end
        end
        S_DIFF: begin
          gap   <= 33'(tgt) - 33'(last_position);
          diff  <= 33'(tgt) - 33'(last_velocity);
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= prod_next;
          vraw  <= vraw_next;
          band  <= band_next;
          state <= S_FIN;
        end
        S_FIN: begin
          if (band == rsl_pkg::BAND_PROFILED) begin
            vel   <= clamp_mag(vraw, cfg.max_velocity);
            state <= S_ACCD;
          end else if (out_free) begin
            drive.command <= fin_cmd;
            drive.band    <= band;
            if (op == rsl_pkg::OP_SPEED) begin
              last_velocity <= fin_cmd;
            end else begin
              last_position <= fin_cmd;
            end
            state <= S_IDLE;
          end
        end
        S_ACCD: begin
          accd  <= 33'(vel) - 33'(last_velocity);
          state <= S_ACCM;
        end
        S_ACCM: begin
          aprod <= accd * T_S;
          pv4t  <= last_velocity * F_S;
          state <= S_ACC;
        end
        S_ACC: begin
          acc   <= clamp_mag(aprod, cfg.max_acceleration);
          state <= S_NUM;
        end
        S_NUM: begin
          n1    <= (NS'(acc) <<< 1) + T_N;
          n2    <= NS'(pv4t) + (NS'(acc) <<< 1) + TT2_N;
          state <= S_SIGN;
        end
        S_SIGN: begin
          neg1  <= n1[NS-1];
          neg2  <= n2[NS-1];
          state <= S_DIV;
        end
        S_DIV: begin
          if (!busy1 && !busy2) begin
            state <= S_PFIN;
          end
        end
        S_PFIN: begin
          if (out_free) begin
            drive.command <= pf_cmd;
            drive.band    <= rsl_pkg::BAND_PROFILED;
            last_position <= pf_cmd;
            last_velocity <= new_vel;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> busy1 == busy2)
    else $error("dividers out of step");

  a_pos_kept: assert property (@(posedge clk) disable iff (rst)
    (state == S_PFIN && out_free) |=> last_position == drive.command)
    else $error("kept position differs from profiled command");

  a_vel_kept: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free && op == rsl_pkg::OP_SPEED)
      |=> last_velocity == drive.command)
    else $error("kept velocity differs from speed command");

endmodule

>>> rtl/ramped_motion_setpoint_limiter_top.sv
// Ramped motion setpoint limiter: config registers, request front end, queue, sequencer.
// Pass-through requests load the output register when popped; speed ramp, snap and near
// requests go through difference, multiply and finish states; profiled ones add acceleration,
// numerator, sign, divide and final states. Throughput: one request per cycle into the queue
// while it is not full; the sequencer holding kept position and velocity takes one at a time.
// Reset (synchronous, active high) clears config registers, kept state, queue and output valid.
module ramped_motion_setpoint_limiter_top #(
  parameter int TICKS_PER_SECOND = rsl_pkg::TICKS_PER_SECOND,
  parameter int QUEUE_DEPTH      = rsl_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            setpoint_valid,
  output logic                            setpoint_stall,
  input  rsl_pkg::setpoint_t              setpoint,
  output logic                            drive_valid,
  input  logic                            drive_stall,
  output rsl_pkg::drive_t                 drive,
  input  logic                            cfg_write,
  input  logic [rsl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rsl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  rsl_pkg::cfg_t   cfg;
  logic            push;
  rsl_pkg::entry_t push_data;
  logic            full;
  logic            q_valid;
  rsl_pkg::entry_t q_head;
  logic            q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        rsl_pkg::REG_CONTROL_MODE:     cfg.control_mode <= cfg_data[1:0];
        rsl_pkg::REG_RAMP_GAIN: begin
          cfg.ramp_gain <= (cfg_data[16:0] > rsl_pkg::ONE_Q16) ? rsl_pkg::ONE_Q16
                                                               : cfg_data[16:0];
        end
        rsl_pkg::REG_MAX_VELOCITY:     cfg.max_velocity     <= cfg_data[30:0];
        rsl_pkg::REG_MAX_ACCELERATION: cfg.max_acceleration <= cfg_data[30:0];
        rsl_pkg::REG_NEAR_TOLERANCE:   cfg.near_tolerance   <= cfg_data[30:0];
        rsl_pkg::REG_SNAP_TOLERANCE:   cfg.snap_tolerance   <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  rsl_front u_front (
    .setpoint_valid (setpoint_valid),
    .setpoint       (setpoint),
    .control_mode   (cfg.control_mode),
    .full           (full),
    .setpoint_stall (setpoint_stall),
    .push           (push),
    .push_data      (push_data)
  );

  rsl_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head),
    .full      (full)
  );

  rsl_back #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .drive_valid (drive_valid),
    .drive_stall (drive_stall),
    .drive       (drive)
  );

endmodule
